FILE: rtl/fmf_pkg.sv
`timescale 1ns / 1ps

package fmf_pkg;

    // Filter geometry
    localparam int TAPS       = 128;
    localparam int COEF_COUNT = 128;

    // Field and datapath widths
    localparam int SAMPLE_W = 8;
    localparam int COEF_W   = 5;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int ACC_W    = 16;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [ACC_W-1:0]    t_acc;

    // Matched-filter template, tap 0 applies to the newest sample
    localparam t_coef COEF_TABLE [COEF_COUNT] = '{
        5'sd10,  5'sd11,  5'sd11,  5'sd8,   5'sd3,   -5'sd3,  -5'sd8,  -5'sd11,
        -5'sd11, -5'sd10, -5'sd10, -5'sd10, -5'sd10, -5'sd10, -5'sd10, -5'sd10,
        -5'sd10, -5'sd10, -5'sd10, -5'sd10, -5'sd10, -5'sd10, -5'sd10, -5'sd10,
        -5'sd10, -5'sd10, -5'sd10, -5'sd10, -5'sd10, -5'sd10,
        -5'sd10, -5'sd10, -5'sd10, -5'sd11, -5'sd11, -5'sd8,  -5'sd3,  5'sd3,
        5'sd8,   5'sd11,  5'sd11,  5'sd10,  5'sd10,  5'sd10,  5'sd10,  5'sd10,
        5'sd10,
        5'sd10,  5'sd10,  5'sd11,  5'sd11,  5'sd8,   5'sd3,   -5'sd3,  -5'sd8,
        -5'sd11, -5'sd11, -5'sd10, -5'sd10, -5'sd10, -5'sd10, -5'sd10, -5'sd10,
        -5'sd10, -5'sd10, -5'sd11, -5'sd11, -5'sd8,  -5'sd3,  5'sd3,   5'sd8,
        5'sd11,  5'sd11,  5'sd10,  5'sd10,  5'sd10,  5'sd10,  5'sd10,  5'sd10,
        5'sd10,
        5'sd10,  5'sd11,  5'sd11,  5'sd8,   5'sd3,   -5'sd3,  -5'sd8,  -5'sd11,
        -5'sd11, -5'sd10, -5'sd10, -5'sd10, -5'sd10, -5'sd10, -5'sd10, -5'sd10,
        -5'sd10, -5'sd11, -5'sd11, -5'sd8,  -5'sd3,  5'sd3,   5'sd8,   5'sd11,
        5'sd11,  5'sd10,  5'sd10,  5'sd10,  5'sd10,  5'sd10,  5'sd10,  5'sd10,
        5'sd10,
        5'sd10,  5'sd10,  5'sd10,  5'sd10,  5'sd10,  5'sd10,  5'sd10,  5'sd10,
        5'sd10,  5'sd10,  5'sd10,  5'sd10,  5'sd10,  5'sd10,  5'sd10
    };

    // Coefficient of a tap; taps past the table weigh zero
    function automatic t_coef tap_coef(input int k);
        t_coef c;
        c = '0;
        if (k >= 0 && k < COEF_COUNT) begin
            c = COEF_TABLE[k];
        end
        return c;
    endfunction

endpackage

FILE: rtl/fmf_tap_cell.sv
`timescale 1ns / 1ps

// One tap of the transposed filter: weights the broadcast sample and adds
// the partial sum handed on by the next cell up the chain.
module fmf_tap_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  fmf_pkg::t_sample i_sample,
    input  fmf_pkg::t_coef   i_coef,
    input  fmf_pkg::t_acc    i_sum,
    output fmf_pkg::t_acc    o_sum
);
    import fmf_pkg::*;

    t_prod w_prod;
    t_acc  r_sum;
    t_acc  n_sum;

    // Constant-coefficient product, then wrapping add
    always_comb begin
        w_prod = PROD_W'(i_sample) * PROD_W'(i_coef);
        n_sum  = i_sum + ACC_W'(w_prod);
    end

    // Partial sum register, advances once per accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_en) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

FILE: rtl/fir_matched_filter_128_tap.sv
`timescale 1ns / 1ps

// 128-tap matched FIR filter, transposed form. Each input word (a signed
// 8-bit sample) is broadcast to a row of tap cells; every cell adds its
// constant-weighted copy of the sample to the partial sum of its upper
// neighbour, so the whole chain moves one step per accepted word. The
// result (16-bit signed, wrapping, no saturation) appears in the output
// register in the cycle after the sample is taken. A new word is taken every
// cycle while the output register is free or being read, so throughput is
// one word per clock; the only stall is back-pressure from the output.
// The filter history sits in the cell partial sums, which reset clears.
module fir_matched_filter_128_tap (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] sample_in
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // [15:0] filtered_out
);
    import fmf_pkg::*;

    t_acc w_sum [TAPS];
    t_sample w_sample;
    logic w_in_take;
    logic w_out_take;
    logic r_out_valid;
    logic n_out_valid;

    assign w_sample   = t_sample'(i_s_tdata[SAMPLE_W-1:0]);
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_in_take  = i_s_tvalid && o_s_tready;
    assign w_out_take = r_out_valid && i_m_tready;

    // Cell chain; cell 0 register doubles as the output data register
    for (genvar g = 0; g < TAPS; g++) begin : g_cell
        t_acc w_up;
        if (g == TAPS - 1) begin : g_top
            assign w_up = '0;
        end else begin : g_mid
            assign w_up = w_sum[g+1];
        end
        fmf_tap_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_in_take),
            .i_sample (w_sample),
            .i_coef   (tap_coef(g)),
            .i_sum    (w_up),
            .o_sum    (w_sum[g])
        );
    end

    // Output word flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_in_take) begin
            n_out_valid = 1'b1;
        end else if (w_out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = w_sum[0];

    // Every taken word yields a result word next cycle
    a_take_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> o_m_tvalid)
        else $error("taken word produced no result");

    // A drained output with nothing new behind it goes empty
    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_take && !w_in_take) |=> !o_m_tvalid)
        else $error("result repeated after being taken");

    // History only moves when a word is taken
    a_chain_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_in_take && $past(i_rst_n)) |=> ($stable(w_sum[1]) && $stable(w_sum[0])))
        else $error("tap chain moved without a taken word");

endmodule
